// File: rtl/core/owsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owsr_pkg
// Shared types and constants of the Search ROM decision engine.
// ----------------------------------------------------------------------------
package owsr_pkg;

	localparam int ROM_BITS    = 64;
	localparam int POS_W       = $clog2(ROM_BITS);
	localparam int TOP_W       = POS_W + 1;
	localparam int STACK_DEPTH = 5;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] MAX_DEV_RESET = 8'd8;
	localparam logic [7:0] COUNT_MAX     = 8'hFF;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_PAIR  = 1'b1;

	typedef enum logic [1:0] {
		PAIR_CONFLICT = 2'b00,
		PAIR_ZERO     = 2'b01,
		PAIR_ONE      = 2'b10,
		PAIR_NONE     = 2'b11
	} pair_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_DEV   = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_FINISHED = 2'd3
	} status_t;

endpackage : owsr_pkg
`default_nettype wire

// File: rtl/core/onewire_search_rom_step_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// onewire_search_rom_step_top
// Per-bit decision engine of the Search ROM: direction bit, conflict stack,
// ROM byte assembly and end-of-pass and end-of-search marking.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid / s_tready    tuser: func, tdata: id_bit, cmp_bit
// m_*       out  m_tvalid / m_tready    tdata: result fields, tlast: pass_done,
//                                       tuser: status
// cfg_*     in   cfg_valid / cfg_ready  cfg_data: max_devices
//
// An item passes from the input register to the output register, so one item
// is taken per cycle while the output is not stalled.
// The path bits live in a 64 x 1 memory read one position ahead of use, with a
// valid bit per entry that reset and the start command clear at once.
// Reset leaves max_devices at 8 and the search cleared.
// A stalled output holds its item while an empty input register still takes one.
// ----------------------------------------------------------------------------
module onewire_search_rom_step_top
	import owsr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] id_bit, [1] cmp_bit
	input  wire logic        s_tuser,   // [0] func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] write_bit, [8:1] rom_byte, [9] byte_valid, [12:10] byte_index,
	// [20:13] device_index, [21] search_done, [29:22] device_count
	output logic [31:0]      m_tdata,
	output logic             m_tlast,   // pass_done
	output logic [1:0]       m_tuser,   // [1:0] status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data   // max_devices
);

	logic                valid_s1;
	logic                func_s1;
	logic                id_s1;
	logic                cmp_s1;

	logic [7:0]          max_dev_q;
	logic [POS_W-1:0]    bitpos_q;
	logic [ROM_BITS-1:0] pvalid_q;
	logic                path_mem [ROM_BITS];
	logic                path_rd_q;
	logic [TOP_W-1:0]    stack_q [STACK_DEPTH+1];
	logic [SP_W-1:0]     sp_q;
	logic [7:0]          shift_q;
	logic [7:0]          count_q;
	logic                finished_q;

	logic                adv;
	logic                fire;
	logic                start;
	logic                active;
	pair_t               pair;
	logic [POS_W-1:0]    idx;
	logic [TOP_W-1:0]    pos;
	logic [TOP_W-1:0]    top;
	logic                path_old;
	logic                wbit;
	status_t             status;
	logic                path_we;
	logic                path_wd;
	logic                push;
	logic [SP_W-1:0]     sp_d;
	logic [POS_W-1:0]    bitpos_d;
	logic [7:0]          shift_new;
	logic                pass_end;
	logic [7:0]          count_new;
	logic                sdone;
	logic                byte_end;

	assign cfg_ready = 1'b1;
	assign adv       = !m_tvalid || m_tready;
	assign s_tready  = !valid_s1 || adv;
	assign fire      = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dev_q <= MAX_DEV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_dev_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			id_s1   <= s_tdata[0];
			cmp_s1  <= s_tdata[1];
		end
	end

	always_comb begin
		start     = fire && (func_s1 == FUNC_START);
		active    = fire && (func_s1 == FUNC_PAIR) && !finished_q;
		pair      = pair_t'({id_s1, cmp_s1});
		idx       = bitpos_q;
		pos       = {1'b0, idx} + TOP_W'(1);
		top       = stack_q[sp_q];
		path_old  = pvalid_q[idx] & path_rd_q;
		wbit      = 1'b0;
		status    = ST_OK;
		path_we   = 1'b0;
		path_wd   = 1'b0;
		push      = 1'b0;
		sp_d      = sp_q;
		unique case (pair)
			PAIR_ZERO: begin
				path_we = 1'b1;
			end
			PAIR_ONE: begin
				wbit    = 1'b1;
				path_we = 1'b1;
				path_wd = 1'b1;
			end
			PAIR_CONFLICT: begin
				priority if (pos > top) begin
					path_we = 1'b1;
					if (sp_q < SP_W'(STACK_DEPTH)) begin
						push = 1'b1;
						sp_d = sp_q + SP_W'(1);
					end else begin
						status = ST_OVERFLOW;
					end
				end else if (pos < top) begin
					wbit = path_old;
				end else begin
					wbit    = 1'b1;
					path_we = 1'b1;
					path_wd = 1'b1;
					if (sp_q != '0) begin
						sp_d = sp_q - SP_W'(1);
					end
				end
			end
			PAIR_NONE: begin
				status = ST_NO_DEV;
			end
			default: begin
				status = ST_NO_DEV;
			end
		endcase
		shift_new = {wbit, shift_q[7:1]};
		pass_end  = (idx == POS_W'(ROM_BITS - 1));
		byte_end  = (idx[2:0] == 3'd7);
		count_new = (count_q != COUNT_MAX) ? count_q + 8'd1 : count_q;
		sdone     = pass_end && ((sp_d == '0) || (count_new >= max_dev_q));
		if (start) begin
			bitpos_d = '0;
		end else if (active) begin
			bitpos_d = idx + POS_W'(1);
		end else begin
			bitpos_d = bitpos_q;
		end
	end

	always_ff @(posedge clk) begin
		if (active && path_we) begin
			path_mem[idx] <= path_wd;
		end
		path_rd_q <= path_mem[bitpos_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitpos_q   <= '0;
			pvalid_q   <= '0;
			sp_q       <= '0;
			shift_q    <= '0;
			count_q    <= '0;
			finished_q <= 1'b0;
			for (int i = 0; i <= STACK_DEPTH; i++) begin
				stack_q[i] <= '0;
			end
		end else begin
			bitpos_q <= bitpos_d;
			if (start) begin
				pvalid_q   <= '0;
				sp_q       <= '0;
				shift_q    <= '0;
				count_q    <= '0;
				finished_q <= 1'b0;
			end else if (active) begin
				if (path_we) begin
					pvalid_q[idx] <= 1'b1;
				end
				if (push) begin
					stack_q[sp_d] <= pos;
				end
				sp_q    <= sp_d;
				shift_q <= pass_end ? 8'd0 : shift_new;
				if (pass_end) begin
					count_q    <= count_new;
					finished_q <= sdone;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (func_s1 == FUNC_START) begin
				m_tdata <= '0;
				m_tlast <= 1'b0;
				m_tuser <= ST_OK;
			end else if (finished_q) begin
				m_tdata <= {2'b00, count_q, 22'd0};
				m_tlast <= 1'b0;
				m_tuser <= ST_FINISHED;
			end else begin
				m_tdata <= {2'b00,
					pass_end ? count_new : count_q,
					sdone,
					count_q,
					idx[5:3],
					byte_end,
					byte_end ? shift_new : 8'd0,
					wbit};
				m_tlast <= pass_end;
				m_tuser <= status;
			end
		end
	end

endmodule : onewire_search_rom_step_top
`default_nettype wire
